[src/cba_pkg.sv]
// cba_pkg: shared constants, codes and types of the cluster bitmap allocator
// used by the channel interfaces, the controller, the datapath and the checker
package cba_pkg;

   localparam int MAP_CLUSTERS = 65536;
   localparam int WORD_BITS    = 32;
   localparam int BIT_W        = $clog2(WORD_BITS);
   localparam int BYTE_W       = BIT_W - 3;
   localparam int WORD_BYTES   = WORD_BITS / 8;
   localparam int MAP_WORDS    = (MAP_CLUSTERS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W       = $clog2(MAP_WORDS);

   localparam int REQ_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int CLUSTER_W = 16;
   localparam int COUNT_W   = 17;

   localparam logic [ADDR_W-1:0]    LAST_WORD         = ADDR_W'(MAP_WORDS - 1);
   localparam logic [CLUSTER_W-1:0] LAST_WORD_WIDE    = CLUSTER_W'(MAP_WORDS - 1);
   localparam logic [CLUSTER_W-1:0] MAP_TOP           = CLUSTER_W'(MAP_CLUSTERS - 1);
   localparam logic [CLUSTER_W-1:0] FIRST_CLUSTER     = CLUSTER_W'(2);
   localparam logic [CLUSTER_W-1:0] MAX_CLUSTER_RESET = CLUSTER_W'(65535);
   localparam logic [COUNT_W-1:0]   COUNT_MAX         = COUNT_W'(MAP_CLUSTERS);
   localparam logic [WORD_BITS-1:0] ALL_USED          = '1;

   typedef enum logic [REQ_W-1:0] {
      REQ_ALLOC = 2'd0,
      REQ_FREE  = 2'd1,
      REQ_MARK  = 2'd2,
      REQ_SCAN  = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOSPACE = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_DECODE,
      S_READ,
      S_MODIFY,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic init_wr;
      logic capture;
      logic rd_en;
      logic modify;
      logic step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic init_last;
      logic needs_map;
      logic walk_done;
      logic rsp_busy;
   } sts_type;

endpackage

[src/cba_intf.sv]
// cba channel interfaces: request, response and register write channels
// depends on cba_pkg for field widths
interface cba_req_if;
   logic                          valid;
   logic                          ready;
   logic [cba_pkg::REQ_W-1:0]     req_type;
   logic [cba_pkg::CLUSTER_W-1:0] cluster;
   logic [cba_pkg::CLUSTER_W-1:0] entry_value;

   modport source (output valid, output req_type, output cluster, output entry_value,
                   input ready);
   modport sink (input valid, input req_type, input cluster, input entry_value,
                 output ready);
endinterface

interface cba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cba_pkg::STATUS_W-1:0]  status;
   logic [cba_pkg::CLUSTER_W-1:0] alloc_cluster;
   logic [cba_pkg::COUNT_W-1:0]   free_count;

   modport source (output valid, output status, output alloc_cluster, output free_count,
                   input ready);
   modport sink (input valid, input status, input alloc_cluster, input free_count,
                 output ready);
endinterface

interface cba_csr_if;
   logic                          valid;
   logic                          ready;
   logic [cba_pkg::CLUSTER_W-1:0] max_cluster;

   modport source (output valid, output max_cluster, input ready);
   modport sink (input valid, input max_cluster, output ready);
endinterface

[src/cluster_bitmap_allocator_core.sv]
// cluster_bitmap_allocator_core: top level, joins the controller and the datapath
// depends on cba_pkg, cba_intf, cba_ctrl, cba_datapath
//
//   channel   dir   handshake          payload
//   req_chan  in    valid/ready        req_type, cluster, entry_value
//   rsp_chan  out   valid/ready        status, alloc_cluster, free_count
//   csr_chan  in    valid/ready        max_cluster
//
// after reset a clearing pass fills all MAP_WORDS (2048) map words with ones, req ready low
// in range free or zero-entry scan: decode, read, modify, finish; else decode, finish
// alloc: a read then a modify per 32-bit map word walked, up to the word of max_cluster
// mark all used: a read then a modify per map word, up to the one holding max_cluster
// each walk step reads one map ram word, then writes it back unless alloc found no clear bit
// a held response does not block the next item until its result is ready to load
module cluster_bitmap_allocator_core (
   input logic       clock,
   input logic       reset,
   cba_req_if.sink   req_chan,
   cba_rsp_if.source rsp_chan,
   cba_csr_if.sink   csr_chan
);

   cba_pkg::cmd_type cmd;
   cba_pkg::sts_type sts;
   logic             req_ready;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   cba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cba_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_type          (req_chan.req_type),
      .req_cluster       (req_chan.cluster),
      .req_entry_value   (req_chan.entry_value),
      .csr_wr            (csr_chan.valid),
      .csr_max_cluster   (csr_chan.max_cluster),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_status        (rsp_chan.status),
      .rsp_alloc_cluster (rsp_chan.alloc_cluster),
      .rsp_free_count    (rsp_chan.free_count)
   );

endmodule

[src/cba_ram.sv]
// cba_ram: generic single-clock ram, one write port, one read port
// registered read data, no dependencies
module cba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/cba_ctrl.sv]
// cba_ctrl: sequencer for the clearing pass and the per-item map walk
// depends on cba_pkg for state, command and status types
module cba_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cba_pkg::sts_type sts,
   output cba_pkg::cmd_type cmd
);

   cba_pkg::state_type state_ff;
   cba_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cba_pkg::S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cba_pkg::S_INIT: begin
            if (sts.init_last) begin
               state_in = cba_pkg::S_IDLE;
            end
         end
         cba_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = cba_pkg::S_DECODE;
            end
         end
         cba_pkg::S_DECODE: begin
            state_in = sts.needs_map ? cba_pkg::S_READ : cba_pkg::S_FINISH;
         end
         cba_pkg::S_READ: begin
            state_in = cba_pkg::S_MODIFY;
         end
         cba_pkg::S_MODIFY: begin
            state_in = sts.walk_done ? cba_pkg::S_FINISH : cba_pkg::S_READ;
         end
         cba_pkg::S_FINISH: begin
            if (!sts.rsp_busy) begin
               state_in = cba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cba_pkg::S_INIT;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         cba_pkg::S_INIT: begin
            cmd.init_wr = 1'b1;
         end
         cba_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         cba_pkg::S_DECODE: begin
         end
         cba_pkg::S_READ: begin
            cmd.rd_en = 1'b1;
         end
         cba_pkg::S_MODIFY: begin
            cmd.modify = 1'b1;
            cmd.step   = !sts.walk_done;
         end
         cba_pkg::S_FINISH: begin
            cmd.load_rsp = !sts.rsp_busy;
         end
         default: begin
         end
      endcase
   end

endmodule

[src/cba_datapath.sv]
// cba_datapath: request registers, word pointer, free count, map ram and response register
// depends on cba_pkg and cba_ram
module cba_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  cba_pkg::cmd_type              cmd,
   output cba_pkg::sts_type              sts,
   input  logic [cba_pkg::REQ_W-1:0]     req_type,
   input  logic [cba_pkg::CLUSTER_W-1:0] req_cluster,
   input  logic [cba_pkg::CLUSTER_W-1:0] req_entry_value,
   input  logic                          csr_wr,
   input  logic [cba_pkg::CLUSTER_W-1:0] csr_max_cluster,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cba_pkg::STATUS_W-1:0]  rsp_status,
   output logic [cba_pkg::CLUSTER_W-1:0] rsp_alloc_cluster,
   output logic [cba_pkg::COUNT_W-1:0]   rsp_free_count
);

   logic [cba_pkg::ADDR_W-1:0]    ptr_ff, ptr_in;
   logic [cba_pkg::CLUSTER_W-1:0] max_cluster_ff;
   logic [cba_pkg::COUNT_W-1:0]   count_ff, count_in;
   cba_pkg::req_code_type         req_code_ff;
   logic [cba_pkg::CLUSTER_W-1:0] cluster_ff;
   logic [cba_pkg::CLUSTER_W-1:0] entry_ff;
   cba_pkg::status_type           status_ff, status_in;
   logic [cba_pkg::CLUSTER_W-1:0] grant_ff, grant_in;
   logic                          rsp_valid_ff;
   cba_pkg::status_type           rsp_status_ff;
   logic [cba_pkg::CLUSTER_W-1:0] rsp_grant_ff;
   logic [cba_pkg::COUNT_W-1:0]   rsp_count_ff;

   cba_pkg::req_code_type         req_code_in;
   logic                          in_ok;
   logic                          held_ok;
   logic                          is_clear_req;
   logic [cba_pkg::CLUSTER_W-1:0] top;
   logic [cba_pkg::ADDR_W-1:0]    top_word;
   logic [cba_pkg::CLUSTER_W-1:0] max_word_wide;
   logic                          mark_full;
   logic [cba_pkg::ADDR_W-1:0]    mark_end;
   logic [cba_pkg::ADDR_W-1:0]    end_word;
   logic                          at_end;
   logic [cba_pkg::WORD_BITS-1:0] rd_data;
   logic [cba_pkg::WORD_BITS-1:0] lo_mask, hi_mask, free_bits, low_bit;
   logic [cba_pkg::BIT_W-1:0]     low_idx;
   logic                          found;
   logic [cba_pkg::WORD_BITS-1:0] mark_mask;
   logic [cba_pkg::WORD_BITS-1:0] clr_mask;
   logic [cba_pkg::WORD_BITS-1:0] wr_data;
   logic                          wr_en;
   logic                          walk_done;

   assign req_code_in = cba_pkg::req_code_type'(req_type);

   assign in_ok = (req_cluster >= cba_pkg::FIRST_CLUSTER) && (req_cluster <= max_cluster_ff)
                  && (req_cluster <= cba_pkg::MAP_TOP);
   assign held_ok = (cluster_ff >= cba_pkg::FIRST_CLUSTER) && (cluster_ff <= max_cluster_ff)
                    && (cluster_ff <= cba_pkg::MAP_TOP);
   assign is_clear_req = (req_code_ff == cba_pkg::REQ_FREE) || (req_code_ff == cba_pkg::REQ_SCAN);

   // search and fill bounds
   assign top = (max_cluster_ff > cba_pkg::MAP_TOP) ? cba_pkg::MAP_TOP : max_cluster_ff;
   assign top_word = top[cba_pkg::ADDR_W+cba_pkg::BIT_W-1:cba_pkg::BIT_W];
   assign max_word_wide = max_cluster_ff >> cba_pkg::BIT_W;
   assign mark_full = max_word_wide > cba_pkg::LAST_WORD_WIDE;
   assign mark_end = mark_full ? cba_pkg::LAST_WORD : max_word_wide[cba_pkg::ADDR_W-1:0];
   assign end_word = (req_code_ff == cba_pkg::REQ_ALLOC) ? top_word : mark_end;
   assign at_end = ptr_ff == end_word;

   // lowest clear candidate in the current word
   assign lo_mask = (ptr_ff == '0)
                    ? ~((cba_pkg::WORD_BITS'(1) << cba_pkg::FIRST_CLUSTER[cba_pkg::BIT_W-1:0])
                        - cba_pkg::WORD_BITS'(1))
                    : cba_pkg::ALL_USED;
   assign hi_mask = (ptr_ff == top_word)
                    ? (cba_pkg::ALL_USED >> (cba_pkg::BIT_W'(cba_pkg::WORD_BITS - 1)
                                             - top[cba_pkg::BIT_W-1:0]))
                    : cba_pkg::ALL_USED;
   assign free_bits = ~rd_data & lo_mask & hi_mask;
   assign found = |free_bits;
   assign low_bit = free_bits & (~free_bits + cba_pkg::WORD_BITS'(1));

   always_comb begin
      low_idx = '0;
      for (int i = 0; i < cba_pkg::WORD_BITS; i++) begin
         if (low_bit[i]) begin
            low_idx = low_idx | cba_pkg::BIT_W'(i);
         end
      end
   end

   // bytes of the current word to mark: all, but in the word holding max_cluster only up to its byte
   always_comb begin
      mark_mask = '0;
      for (int b = 0; b < cba_pkg::WORD_BYTES; b++) begin
         if ((ptr_ff != mark_end) || mark_full
             || (cba_pkg::BYTE_W'(b) <= max_cluster_ff[cba_pkg::BIT_W-1:3])) begin
            mark_mask[b*8 +: 8] = 8'hff;
         end
      end
   end

   assign clr_mask = cba_pkg::ALL_USED
                     ^ (cba_pkg::WORD_BITS'(1) << cluster_ff[cba_pkg::BIT_W-1:0]);

   always_comb begin
      wr_data = cba_pkg::ALL_USED;
      if (!cmd.init_wr) begin
         case (req_code_ff)
            cba_pkg::REQ_ALLOC: wr_data = rd_data | low_bit;
            cba_pkg::REQ_MARK:  wr_data = rd_data | mark_mask;
            default:            wr_data = rd_data & clr_mask;
         endcase
      end
   end

   assign wr_en = cmd.init_wr
                  || (cmd.modify && ((req_code_ff != cba_pkg::REQ_ALLOC) || found));
   assign walk_done = is_clear_req || ((req_code_ff == cba_pkg::REQ_ALLOC) && found) || at_end;

   cba_ram #(
      .WIDTH (cba_pkg::WORD_BITS),
      .DEPTH (cba_pkg::MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ptr_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.init_wr) begin
         ptr_in = (ptr_ff == cba_pkg::LAST_WORD) ? '0 : ptr_ff + cba_pkg::ADDR_W'(1);
      end else if (cmd.capture) begin
         if ((req_code_in == cba_pkg::REQ_FREE) || (req_code_in == cba_pkg::REQ_SCAN)) begin
            ptr_in = req_cluster[cba_pkg::ADDR_W+cba_pkg::BIT_W-1:cba_pkg::BIT_W];
         end else begin
            ptr_in = '0;
         end
      end else if (cmd.step) begin
         ptr_in = ptr_ff + cba_pkg::ADDR_W'(1);
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      grant_in  = grant_ff;
      if (cmd.capture) begin
         grant_in  = '0;
         status_in = cba_pkg::STATUS_OK;
         if (((req_code_in == cba_pkg::REQ_FREE) || (req_code_in == cba_pkg::REQ_SCAN))
             && !in_ok) begin
            status_in = cba_pkg::STATUS_RANGE;
         end
      end else if (cmd.modify && walk_done) begin
         case (req_code_ff)
            cba_pkg::REQ_ALLOC: begin
               if (found) begin
                  grant_in = cba_pkg::CLUSTER_W'({ptr_ff, low_idx});
                  if (count_ff != '0) begin
                     count_in = count_ff - cba_pkg::COUNT_W'(1);
                  end
               end else begin
                  status_in = cba_pkg::STATUS_NOSPACE;
               end
            end
            cba_pkg::REQ_MARK: begin
               count_in = '0;
            end
            default: begin
               if (count_ff < cba_pkg::COUNT_MAX) begin
                  count_in = count_ff + cba_pkg::COUNT_W'(1);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff         <= '0;
         count_ff       <= '0;
         max_cluster_ff <= cba_pkg::MAX_CLUSTER_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         ptr_ff   <= ptr_in;
         count_ff <= count_in;
         if (csr_wr) begin
            max_cluster_ff <= csr_max_cluster;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      grant_ff  <= grant_in;
      if (cmd.capture) begin
         req_code_ff <= req_code_in;
         cluster_ff  <= req_cluster;
         entry_ff    <= req_entry_value;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_grant_ff  <= grant_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign sts.init_last = ptr_ff == cba_pkg::LAST_WORD;
   assign sts.needs_map = !is_clear_req
                          || (held_ok && ((req_code_ff == cba_pkg::REQ_FREE) || (entry_ff == '0)));
   assign sts.walk_done = walk_done;
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_alloc_cluster = rsp_grant_ff;
   assign rsp_free_count    = rsp_count_ff;

endmodule

[src/cba_checker.sv]
// cba_checker: port-level assertions on the allocator top level
// depends on cba_pkg, bound to cluster_bitmap_allocator_core
module cba_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [cba_pkg::STATUS_W-1:0]  rsp_status,
   input logic [cba_pkg::CLUSTER_W-1:0] rsp_alloc_cluster,
   input logic [cba_pkg::COUNT_W-1:0]   rsp_free_count
);

   // stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_alloc_cluster) && $stable(rsp_free_count))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != cba_pkg::STATUS_OK) |-> rsp_alloc_cluster == '0)
      else $error("grant on failed request");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == cba_pkg::STATUS_OK) && (rsp_alloc_cluster != '0)
         |-> rsp_alloc_cluster >= cba_pkg::FIRST_CLUSTER)
      else $error("reserved cluster granted");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_count <= cba_pkg::COUNT_MAX)
      else $error("free count above map size");

   // clearing pass keeps requests out
   assert property (@(posedge clock) $fell(reset) |-> !req_ready)
      else $error("request ready during clearing pass");

endmodule

bind cluster_bitmap_allocator_core cba_checker u_cba_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_alloc_cluster (rsp_chan.alloc_cluster),
   .rsp_free_count    (rsp_chan.free_count)
);

[sim/tb_cluster_bitmap_allocator_core.sv]
`timescale 1ns / 1ps
// tb_cluster_bitmap_allocator_core: self-checking bench for the cluster bitmap allocator core,
// a directed table then random and gap-free request streams scored against a bitmap predictor
// depends on cba_pkg, the cba channel interfaces and cluster_bitmap_allocator_core
module tb_cluster_bitmap_allocator_core;

   localparam int LIMIT_CYCLES = 40_000_000;
   localparam int MAP_WORD_CNT = cba_pkg::MAP_CLUSTERS / 32;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      cba_pkg::status_type           status;
      logic [cba_pkg::CLUSTER_W-1:0] alloc_cluster;
      logic [cba_pkg::COUNT_W-1:0]   free_count;
   } answer_type;

   typedef struct packed {
      logic                          is_cfg;
      cba_pkg::req_code_type         op;
      logic [cba_pkg::CLUSTER_W-1:0] cluster;
      logic [cba_pkg::CLUSTER_W-1:0] entry;
      logic                          pinned;
      answer_type                    ans;
   } plan_row_type;

   logic clock;
   logic reset;

   cba_req_if req_if ();
   cba_rsp_if rsp_if ();
   cba_csr_if csr_if ();

   cluster_bitmap_allocator_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source),
      .csr_chan (csr_if.sink)
   );

   // bitmap predictor state
   logic [31:0]                   map_words [0:MAP_WORD_CNT-1];
   logic [cba_pkg::COUNT_W-1:0]   free_q;
   logic [cba_pkg::CLUSTER_W-1:0] limit_q;

   answer_type   answers_due [$];
   plan_row_type plan [$];

   logic       req_pinned;
   answer_type req_pin_ans;
   bit         idle_en;
   bit         hold_rsp;
   int         mismatches;
   int         n_req, n_grant, n_nospace, n_range, n_cfg;
   int         peak_free;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic answer_type bitmap_update(cba_pkg::req_code_type op,
                                                logic [cba_pkg::CLUSTER_W-1:0] c,
                                                logic [cba_pkg::CLUSTER_W-1:0] e);
      answer_type a;
      int         top;
      int         cn;
      bit         found;
      bit         in_range;
      a.status        = cba_pkg::STATUS_OK;
      a.alloc_cluster = '0;
      in_range = (c >= cba_pkg::FIRST_CLUSTER) && (c <= limit_q)
                 && (int'(c) < cba_pkg::MAP_CLUSTERS);
      found    = 1'b0;
      case (op)
         cba_pkg::REQ_ALLOC: begin
            top = (int'(limit_q) > cba_pkg::MAP_CLUSTERS - 1) ? cba_pkg::MAP_CLUSTERS - 1
                                                               : int'(limit_q);
            cn  = int'(cba_pkg::FIRST_CLUSTER);
            while (cn <= top && !found) begin
               if (map_words[cn >> 5] == '1) cn = (cn | 31) + 1;
               else if (!map_words[cn >> 5][cn & 31]) found = 1'b1;
               else cn++;
            end
            if (found) begin
               map_words[cn >> 5][cn & 31] = 1'b1;
               if (free_q != 0) free_q--;
               a.alloc_cluster = cba_pkg::CLUSTER_W'(cn);
            end else begin
               a.status = cba_pkg::STATUS_NOSPACE;
            end
         end
         cba_pkg::REQ_MARK: begin
            for (int b = 0; b <= int'(limit_q >> 3) && b < cba_pkg::MAP_CLUSTERS / 8; b++)
               map_words[b >> 2][(b & 3) * 8 +: 8] = 8'hff;
            free_q = '0;
         end
         default: begin
            if (!in_range) begin
               a.status = cba_pkg::STATUS_RANGE;
            end else if (op == cba_pkg::REQ_FREE || e == '0) begin
               map_words[c >> 5][c[4:0]] = 1'b0;
               if (free_q < cba_pkg::COUNT_MAX) free_q++;
            end
         end
      endcase
      a.free_count = free_q;
      return a;
   endfunction

   task automatic check_field(string what, int want, int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // scoreboard: predict on request acceptance, compare on response acceptance
   always @(posedge clock) begin : score
      answer_type want_a;
      answer_type pred_a;
      if (reset) begin
         for (int w = 0; w < MAP_WORD_CNT; w++) map_words[w] = '1;
         free_q  = '0;
         limit_q = cba_pkg::MAX_CLUSTER_RESET;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (answers_due.size() == 0) begin
               mismatches++;
               $display("%0t: response with nothing expected, actual status %0d cluster %0d count %0d",
                        $time, rsp_if.status, rsp_if.alloc_cluster, rsp_if.free_count);
            end else begin
               want_a = answers_due.pop_front();
               check_field("status", int'(want_a.status), int'(rsp_if.status));
               check_field("alloc_cluster", int'(want_a.alloc_cluster), int'(rsp_if.alloc_cluster));
               check_field("free_count", int'(want_a.free_count), int'(rsp_if.free_count));
            end
         end
         if (csr_if.valid && csr_if.ready) begin
            limit_q = csr_if.max_cluster;
            n_cfg++;
         end
         if (req_if.valid && req_if.ready) begin
            pred_a = bitmap_update(cba_pkg::req_code_type'(req_if.req_type), req_if.cluster,
                                   req_if.entry_value);
            want_a = req_pinned ? req_pin_ans : pred_a;
            answers_due.push_back(want_a);
            n_req++;
            if (want_a.status == cba_pkg::STATUS_NOSPACE) n_nospace++;
            if (want_a.status == cba_pkg::STATUS_RANGE) n_range++;
            if (want_a.status == cba_pkg::STATUS_OK && req_if.req_type == cba_pkg::REQ_ALLOC)
               n_grant++;
            if (int'(want_a.free_count) > peak_free) peak_free = int'(want_a.free_count);
         end
      end
   end

   // response side: random stalls plus one long hold on request
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (idle_en && $urandom_range(0, 9) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("timeout after %0d cycles, %0d responses outstanding", LIMIT_CYCLES,
               answers_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic send_item(cba_pkg::req_code_type op, logic [cba_pkg::CLUSTER_W-1:0] c,
                            logic [cba_pkg::CLUSTER_W-1:0] e, logic pin, answer_type pin_ans);
      if (idle_en && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.req_type    <= op;
      req_if.cluster     <= c;
      req_if.entry_value <= e;
      req_pinned         <= pin;
      req_pin_ans        <= pin_ans;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(logic [cba_pkg::CLUSTER_W-1:0] v);
      csr_if.valid       <= 1'b1;
      csr_if.max_cluster <= v;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   function automatic void add_req(cba_pkg::req_code_type op, int c, int e);
      plan.push_back('{1'b0, op, cba_pkg::CLUSTER_W'(c), cba_pkg::CLUSTER_W'(e), 1'b0, '0});
   endfunction

   function automatic void add_pinned(cba_pkg::req_code_type op, int c, int e,
                                      cba_pkg::status_type st, int g, int f);
      answer_type a;
      a.status        = st;
      a.alloc_cluster = cba_pkg::CLUSTER_W'(g);
      a.free_count    = cba_pkg::COUNT_W'(f);
      plan.push_back('{1'b0, op, cba_pkg::CLUSTER_W'(c), cba_pkg::CLUSTER_W'(e), 1'b1, a});
   endfunction

   function automatic void add_limit(int v);
      plan.push_back('{1'b1, cba_pkg::REQ_ALLOC, cba_pkg::CLUSTER_W'(v), '0, 1'b0, '0});
   endfunction

   function automatic logic [cba_pkg::CLUSTER_W-1:0] pick_valid(int m);
      if (m > 300 && $urandom_range(0, 1) == 1)
         return cba_pkg::CLUSTER_W'($urandom_range(2, 300));
      return cba_pkg::CLUSTER_W'($urandom_range(2, m));
   endfunction

   function automatic logic [cba_pkg::CLUSTER_W-1:0] pick_invalid(int m);
      if (m == 65535 || $urandom_range(0, 1) == 1)
         return cba_pkg::CLUSTER_W'($urandom_range(0, 1));
      return cba_pkg::CLUSTER_W'($urandom_range(m + 1, 65535));
   endfunction

   task automatic random_item(int m);
      int                            k;
      logic [cba_pkg::CLUSTER_W-1:0] c;
      logic [cba_pkg::CLUSTER_W-1:0] e;
      k = $urandom_range(0, 99);
      c = cba_pkg::CLUSTER_W'($urandom);
      e = cba_pkg::CLUSTER_W'($urandom);
      if (k < 30) send_item(cba_pkg::REQ_ALLOC, c, e, 1'b0, '0);
      else if (k < 55) send_item(cba_pkg::REQ_SCAN, pick_valid(m), '0, 1'b0, '0);
      else if (k < 65) send_item(cba_pkg::REQ_SCAN, pick_valid(m),
                                 cba_pkg::CLUSTER_W'($urandom_range(1, 65535)), 1'b0, '0);
      else if (k < 82) send_item(cba_pkg::REQ_FREE, pick_valid(m), e, 1'b0, '0);
      else if (k < 87) send_item(cba_pkg::REQ_MARK, c, e, 1'b0, '0);
      else send_item(k[0] ? cba_pkg::REQ_FREE : cba_pkg::REQ_SCAN, pick_invalid(m),
                     (k < 94) ? '0 : e, 1'b0, '0);
   endtask

   initial begin : stimulus
      int phase_limit [13];
      int cnt;
      clock = 1'b0;
      reset <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.req_type    <= cba_pkg::REQ_ALLOC;
      req_if.cluster     <= '0;
      req_if.entry_value <= '0;
      csr_if.valid       <= 1'b0;
      csr_if.max_cluster <= cba_pkg::MAX_CLUSTER_RESET;
      req_pinned  <= 1'b0;
      req_pin_ans <= '0;
      idle_en  = 1'b1;
      hold_rsp = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table, limit starts at its reset value
      add_pinned(cba_pkg::REQ_ALLOC, 0, 0, cba_pkg::STATUS_NOSPACE, 0, 0);
      add_pinned(cba_pkg::REQ_FREE, 0, 0, cba_pkg::STATUS_RANGE, 0, 0);
      add_pinned(cba_pkg::REQ_SCAN, 1, 0, cba_pkg::STATUS_RANGE, 0, 0);
      add_pinned(cba_pkg::REQ_FREE, 65535, 0, cba_pkg::STATUS_OK, 0, 1);
      add_pinned(cba_pkg::REQ_SCAN, 2, 0, cba_pkg::STATUS_OK, 0, 2);
      add_pinned(cba_pkg::REQ_SCAN, 3, 65535, cba_pkg::STATUS_OK, 0, 2);
      add_pinned(cba_pkg::REQ_FREE, 2, 0, cba_pkg::STATUS_OK, 0, 3);
      add_pinned(cba_pkg::REQ_ALLOC, 0, 0, cba_pkg::STATUS_OK, 2, 2);
      add_pinned(cba_pkg::REQ_ALLOC, 65535, 65535, cba_pkg::STATUS_OK, 65535, 1);
      add_pinned(cba_pkg::REQ_ALLOC, 0, 0, cba_pkg::STATUS_NOSPACE, 0, 1);
      add_pinned(cba_pkg::REQ_MARK, 0, 0, cba_pkg::STATUS_OK, 0, 0);
      add_pinned(cba_pkg::REQ_SCAN, 10, 0, cba_pkg::STATUS_OK, 0, 1);
      add_limit(7);
      add_pinned(cba_pkg::REQ_FREE, 8, 0, cba_pkg::STATUS_RANGE, 0, 1);
      add_pinned(cba_pkg::REQ_SCAN, 7, 0, cba_pkg::STATUS_OK, 0, 2);
      add_pinned(cba_pkg::REQ_MARK, 65535, 65535, cba_pkg::STATUS_OK, 0, 0);
      add_pinned(cba_pkg::REQ_ALLOC, 0, 0, cba_pkg::STATUS_NOSPACE, 0, 0);
      add_limit(65535);
      // count already zero, grant leaves it there
      add_pinned(cba_pkg::REQ_ALLOC, 0, 0, cba_pkg::STATUS_OK, 10, 0);
      add_limit(2);
      add_pinned(cba_pkg::REQ_SCAN, 2, 0, cba_pkg::STATUS_OK, 0, 1);
      add_pinned(cba_pkg::REQ_ALLOC, 0, 0, cba_pkg::STATUS_OK, 2, 0);
      add_pinned(cba_pkg::REQ_FREE, 3, 0, cba_pkg::STATUS_RANGE, 0, 0);
      add_pinned(cba_pkg::REQ_FREE, 65535, 65535, cba_pkg::STATUS_RANGE, 0, 0);
      add_req(cba_pkg::REQ_ALLOC, 21845, 43690);
      add_req(cba_pkg::REQ_SCAN, 2, 1);

      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            settle();
            write_limit(plan[i].cluster);
         end else begin
            send_item(plan[i].op, plan[i].cluster, plan[i].entry, plan[i].pinned, plan[i].ans);
         end
      end

      // random phases over several limits, mostly small maps
      phase_limit = '{2, 31, 32, 65535, 33, 255, 4095, 0, 0, 0, 0, 0, 0};
      for (int p = 7; p < 13; p++) phase_limit[p] = $urandom_range(3, 1023);
      foreach (phase_limit[p]) begin
         settle();
         write_limit(cba_pkg::CLUSTER_W'(phase_limit[p]));
         cnt = (phase_limit[p] == 65535) ? 40 : 140;
         for (int i = 0; i < cnt; i++) begin
            if (p == 1 && i == 20) hold_rsp = 1'b1;
            if (p == 2 && i == 70) settle();
            random_item(phase_limit[p]);
         end
      end

      // closing stretch without gaps: frees and scans back to back, then allocate, then one last free
      settle();
      idle_en = 1'b0;
      write_limit(cba_pkg::MAX_CLUSTER_RESET);
      for (int i = 0; i < 60; i++) begin
         if (i % 2 == 1) send_item(cba_pkg::REQ_FREE, cba_pkg::CLUSTER_W'($urandom_range(2, 65535)),
                                   cba_pkg::CLUSTER_W'($urandom), 1'b0, '0);
         else send_item(cba_pkg::REQ_SCAN, cba_pkg::CLUSTER_W'($urandom_range(2, 65535)), '0,
                        1'b0, '0);
      end
      for (int i = 0; i < 6; i++)
         send_item(cba_pkg::REQ_ALLOC, cba_pkg::CLUSTER_W'($urandom), '0, 1'b0, '0);
      send_item(cba_pkg::REQ_FREE, 2, 0, 1'b0, '0);
      req_if.valid <= 1'b0;

      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      $display("%0d requests across %0d limit writes: %0d grants, %0d no space, %0d out of range",
               n_req, n_cfg, n_grant, n_nospace, n_range);
      $display("free count peaked at %0d of %0d", peak_free, cba_pkg::COUNT_MAX);
      if (mismatches == 0 && answers_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[files.f]
src/cba_pkg.sv
src/cba_intf.sv
src/cba_ram.sv
src/cba_ctrl.sv
src/cba_datapath.sv
src/cluster_bitmap_allocator_core.sv
src/cba_checker.sv
sim/tb_cluster_bitmap_allocator_core.sv
